@@ rtl/fm_voice_command_to_register_writes_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros for the fm voice command sequencer
// ---------------------------------------------------------------------------
`ifndef FM_VOICE_COMMAND_TO_REGISTER_WRITES_MACROS_SVH
`define FM_VOICE_COMMAND_TO_REGISTER_WRITES_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define FMV_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define FMV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/fmv_pkg.sv @@
// ---------------------------------------------------------------------------
// fmv_pkg
// types, register map constants and slot tables for the fm voice sequencer
// ---------------------------------------------------------------------------
package fmv_pkg;

    // longest command: five modulator, five carrier and one feedback write
    localparam int MAX_WR = 11;
    localparam int CNT_W  = $clog2(MAX_WR + 1);
    localparam int IDX_W  = $clog2(MAX_WR);
    localparam int NUM_KB = 9;
    localparam int KB_W   = $clog2(NUM_KB);

    // command codes
    localparam logic [2:0] OP_KEY_ON  = 3'd0;
    localparam logic [2:0] OP_KEY_OFF = 3'd1;
    localparam logic [2:0] OP_VOLUME  = 3'd2;
    localparam logic [2:0] OP_INSTR   = 3'd3;
    localparam logic [2:0] OP_PERC    = 3'd4;

    // chip register map
    localparam logic [7:0] REG_RHYTHM  = 8'hBD;
    localparam logic [7:0] RHYTHM_ON   = 8'h20;
    localparam logic [7:0] REG_FNUM_LO = 8'hA0;
    localparam logic [7:0] REG_KEYBLK  = 8'hB0;
    localparam logic [7:0] REG_LEVEL   = 8'h40;
    localparam logic [7:0] REG_FBCONN  = 8'hC0;
    localparam logic [7:0] KEY_ON_BIT  = 8'h20;
    localparam logic [7:0] KEY_OFF_MSK = 8'hDF;

    // noise generator pitches for the snare (7) and tom (8) channels
    localparam logic [3:0]  NOISE_CH_A   = 4'd7;
    localparam logic [3:0]  NOISE_CH_B   = 4'd8;
    localparam logic [12:0] NOISE_FREQ_A = 13'd1844;
    localparam logic [12:0] NOISE_FREQ_B = 13'd3764;

    // voice numbers that matter in rhythm mode
    localparam logic [3:0] V_LAST_MEL  = 4'd8;
    localparam logic [3:0] V_LAST_DRUM = 4'd10;
    localparam logic [3:0] V_FIRST_DR  = 4'd6;
    localparam logic [3:0] V_BASS      = 4'd6;
    localparam logic [3:0] V_TOM       = 4'd8;
    localparam logic [3:0] V_SNARE     = 4'd7;
    localparam logic [7:0] DRUM_TOP    = 8'h10;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [3:0]  voice;
        logic [12:0] freq;
        logic [7:0]  volume;
        logic        percussion_on;
        logic [39:0] modulator_bytes;
        logic [39:0] carrier_bytes;
        logic [2:0]  feedback;
        logic        fm_connection;
    } t_in;

    typedef struct packed {
        logic [7:0] reg_address;
        logic [7:0] reg_data;
        logic       write_valid;
        logic       last;
    } t_out;

    // one register write
    typedef struct packed {
        logic [7:0] addr;
        logic [7:0] data;
    } t_wr;

    // expanded command handed from the decoder to the output sequencer
    typedef struct packed {
        logic [CNT_W-1:0]  count;
        logic              wvalid;
        t_wr [MAX_WR-1:0]  wr;
    } t_dec;

    // state update that goes with one command
    typedef struct packed {
        logic       perc;
        logic [7:0] rhythm;
        logic       kb_we;
        logic [3:0] kb_idx;
        logic [7:0] kb_val;
    } t_upd;

    // operator register bases
    function automatic logic [7:0] op_base(input logic [2:0] k);
        logic [7:0] b;
        case (k)
            3'd0:    b = 8'h20;
            3'd1:    b = 8'h40;
            3'd2:    b = 8'h60;
            3'd3:    b = 8'h80;
            default: b = 8'hE0;
        endcase
        return b;
    endfunction

    // operator slot to register offset
    function automatic logic [7:0] slot_offset(input logic [4:0] s);
        logic [7:0] o;
        case (s)
            5'd0:    o = 8'h00;
            5'd1:    o = 8'h01;
            5'd2:    o = 8'h02;
            5'd3:    o = 8'h03;
            5'd4:    o = 8'h04;
            5'd5:    o = 8'h05;
            5'd6:    o = 8'h08;
            5'd7:    o = 8'h09;
            5'd8:    o = 8'h0A;
            5'd9:    o = 8'h0B;
            5'd10:   o = 8'h0C;
            5'd11:   o = 8'h0D;
            5'd12:   o = 8'h10;
            5'd13:   o = 8'h11;
            5'd14:   o = 8'h12;
            5'd15:   o = 8'h13;
            5'd16:   o = 8'h14;
            5'd17:   o = 8'h15;
            default: o = 8'h00;
        endcase
        return o;
    endfunction

    // modulator slot of each voice
    function automatic logic [4:0] mod_slot(input logic [3:0] v);
        logic [4:0] s;
        case (v)
            4'd0:    s = 5'd0;
            4'd1:    s = 5'd1;
            4'd2:    s = 5'd2;
            4'd3:    s = 5'd6;
            4'd4:    s = 5'd7;
            4'd5:    s = 5'd8;
            4'd6:    s = 5'd12;
            4'd7:    s = 5'd13;
            4'd8:    s = 5'd14;
            4'd9:    s = 5'd17;
            4'd10:   s = 5'd13;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // carrier slot of each melodic voice
    function automatic logic [4:0] car_slot(input logic [3:0] v);
        logic [4:0] s;
        case (v)
            4'd0:    s = 5'd3;
            4'd1:    s = 5'd4;
            4'd2:    s = 5'd5;
            4'd3:    s = 5'd9;
            4'd4:    s = 5'd10;
            4'd5:    s = 5'd11;
            4'd6:    s = 5'd15;
            4'd7:    s = 5'd16;
            4'd8:    s = 5'd17;
            default: s = 5'd3;
        endcase
        return s;
    endfunction

endpackage

@@ rtl/fmv_decode.sv @@
// ---------------------------------------------------------------------------
// fmv_decode
// expands one voice command into its list of register writes and the
// state update that goes with it
// ---------------------------------------------------------------------------
module fmv_decode (
    input  fmv_pkg::t_in  i_item,
    input  logic          i_perc,
    input  logic [7:0]    i_rhythm,
    input  logic [7:0]    i_kb_rd,
    output fmv_pkg::t_dec o_dec,
    output fmv_pkg::t_upd o_upd
);
    import fmv_pkg::*;

    always_comb begin
        logic [CNT_W-1:0] n;
        logic             drum;
        logic             v_ok;
        logic [3:0]       v;
        logic [7:0]       mo;
        logic [7:0]       co;
        logic [7:0]       rbit;
        logic [7:0]       kb;

        v     = i_item.voice;
        n     = '0;
        o_dec = '0;
        o_dec.wvalid = 1'b1;
        o_upd.perc   = i_perc;
        o_upd.rhythm = i_rhythm;
        o_upd.kb_we  = 1'b0;
        o_upd.kb_idx = v;
        o_upd.kb_val = '0;

        drum = i_perc && (v >= V_FIRST_DR);
        v_ok = i_perc ? (v <= V_LAST_DRUM) : (v <= V_LAST_MEL);
        // snare modulator moves to the rhythm slot in percussion mode
        mo   = (i_perc && (v == V_SNARE)) ? slot_offset(5'd16) : slot_offset(mod_slot(v));
        co   = slot_offset(car_slot(v));
        rbit = DRUM_TOP >> (v - V_FIRST_DR);
        kb   = {3'b000, i_item.freq[12:8]} | KEY_ON_BIT;

        if (i_item.opcode == OP_PERC) begin
            // rhythm mode switch
            if (i_item.percussion_on) begin
                o_upd.perc   = 1'b1;
                o_upd.rhythm = RHYTHM_ON;
                o_dec.wr[0]  = '{addr: REG_RHYTHM, data: RHYTHM_ON};
                o_dec.wr[1]  = '{addr: REG_FNUM_LO + {4'b0000, NOISE_CH_A},
                                 data: NOISE_FREQ_A[7:0]};
                o_dec.wr[2]  = '{addr: REG_KEYBLK + {4'b0000, NOISE_CH_A},
                                 data: {3'b000, NOISE_FREQ_A[12:8]}};
                o_dec.wr[3]  = '{addr: REG_FNUM_LO + {4'b0000, NOISE_CH_B},
                                 data: NOISE_FREQ_B[7:0]};
                o_dec.wr[4]  = '{addr: REG_KEYBLK + {4'b0000, NOISE_CH_B},
                                 data: {3'b000, NOISE_FREQ_B[12:8]}};
                n = CNT_W'(5);
            end else begin
                o_upd.perc   = 1'b0;
                o_upd.rhythm = '0;
                o_dec.wr[0]  = '{addr: REG_RHYTHM, data: 8'h00};
                n = CNT_W'(1);
            end
        end else if ((i_item.opcode > OP_PERC) || !v_ok) begin
            // rejected command: one empty result
            o_dec.wvalid = 1'b0;
            n = CNT_W'(1);
        end else begin
            unique case (i_item.opcode)
                OP_KEY_ON: begin
                    if (drum) begin
                        o_upd.rhythm = i_rhythm | rbit;
                        if ((v == V_BASS) || (v == V_TOM)) begin
                            o_dec.wr[0] = '{addr: REG_FNUM_LO + {4'b0000, v},
                                            data: i_item.freq[7:0]};
                            o_dec.wr[1] = '{addr: REG_KEYBLK + {4'b0000, v},
                                            data: {3'b000, i_item.freq[12:8]}};
                            n = CNT_W'(2);
                        end
                        o_dec.wr[n[IDX_W-1:0]] = '{addr: REG_RHYTHM, data: i_rhythm | rbit};
                        n = n + CNT_W'(1);
                    end else begin
                        o_dec.wr[0]  = '{addr: REG_FNUM_LO + {4'b0000, v},
                                         data: i_item.freq[7:0]};
                        o_dec.wr[1]  = '{addr: REG_KEYBLK + {4'b0000, v}, data: kb};
                        o_upd.kb_we  = 1'b1;
                        o_upd.kb_val = kb;
                        n = CNT_W'(2);
                    end
                end
                OP_KEY_OFF: begin
                    if (drum) begin
                        o_upd.rhythm = i_rhythm & ~rbit;
                        o_dec.wr[0]  = '{addr: REG_RHYTHM, data: i_rhythm & ~rbit};
                    end else begin
                        o_dec.wr[0]  = '{addr: REG_KEYBLK + {4'b0000, v},
                                         data: i_kb_rd & KEY_OFF_MSK};
                    end
                    n = CNT_W'(1);
                end
                OP_VOLUME: begin
                    o_dec.wr[0] = '{addr: REG_LEVEL + mo, data: i_item.volume};
                    n = CNT_W'(1);
                end
                default: begin
                    // instrument: modulator operator, then carrier and feedback except for drums 7 to 10
                    for (int k = 0; k < 5; k++) begin
                        o_dec.wr[k] = '{addr: op_base(3'(k)) + mo,
                                        data: i_item.modulator_bytes[8*k +: 8]};
                    end
                    n = CNT_W'(5);
                    if (!i_perc || (v < V_SNARE)) begin
                        for (int k = 0; k < 5; k++) begin
                            o_dec.wr[k + 5] = '{addr: op_base(3'(k)) + co,
                                                data: i_item.carrier_bytes[8*k +: 8]};
                        end
                        o_dec.wr[10] = '{addr: REG_FBCONN + {4'b0000, v},
                                         data: {4'b0000, i_item.feedback,
                                                ~i_item.fm_connection}};
                        n = CNT_W'(MAX_WR);
                    end
                end
            endcase
        end
        o_dec.count = n;
    end

endmodule

@@ rtl/fmv_emit.sv @@
// ---------------------------------------------------------------------------
// fmv_emit
// result register: holds the expanded writes of one command and shifts
// them out one per accepted request
// ---------------------------------------------------------------------------
`include "fm_voice_command_to_register_writes_macros.svh"

module fmv_emit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  fmv_pkg::t_dec i_dec,
    output logic          o_free,
    output logic          o_valid,
    output fmv_pkg::t_out o_out,
    input  logic          i_stall
);
    import fmv_pkg::*;

    localparam logic [CNT_W-1:0] LAST_LEFT = CNT_W'(1);

    logic                r_valid;
    logic [CNT_W-1:0]    r_left;
    logic                r_wv;
    t_wr                 r_wr [MAX_WR];
    logic                take;

    // output handshake
    assign take    = r_valid && !i_stall;
    assign o_free  = !r_valid || (take && (r_left == LAST_LEFT));
    assign o_valid = r_valid;
    assign o_out   = '{reg_address: r_wr[0].addr, reg_data: r_wr[0].data,
                       write_valid: r_wv, last: (r_left == LAST_LEFT)};

    // control: occupancy and remaining count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_left  <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_left  <= i_dec.count;
        end else if (take) begin
            r_valid <= (r_left != LAST_LEFT);
            r_left  <= r_left - CNT_W'(1);
        end
    end

    // payload: load the whole list or shift down by one
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_wv <= i_dec.wvalid;
            for (int k = 0; k < MAX_WR; k++) begin
                r_wr[k] <= i_dec.wr[k];
            end
        end else if (take) begin
            for (int k = 0; k < MAX_WR - 1; k++) begin
                r_wr[k] <= r_wr[k + 1];
            end
        end
    end

    `FMV_ASSERT_SAME(a_left_range, r_valid, (r_left != '0) && (r_left <= CNT_W'(MAX_WR)), "remaining count out of range")
    `FMV_ASSERT_SAME(a_load_free, i_load, !r_valid || (take && (r_left == LAST_LEFT)), "load over a pending command")
    `FMV_ASSERT_NEXT(a_shift, take && (r_left != LAST_LEFT), r_valid && (r_left == $past(r_left) - CNT_W'(1)), "write lost")
    `FMV_ASSERT_SAME(a_reject_one, r_valid && !r_wv, r_left == LAST_LEFT, "rejected command gives more than one result")

endmodule

@@ rtl/fm_voice_command_to_register_writes.sv @@
// A command is held in the input register, then moves into the result register, which drives the writes.
// One register write per cycle while the write side does not stall; a command gives 1 to 11 writes.
// The next command is taken while the last write of the previous one is delivered.
// The rate is set by the single output port of the result shift register.
// Reset (synchronous, active low) empties both stages, sets melodic mode and clears shadows.
// ---------------------------------------------------------------------------
// fm_voice_command_to_register_writes
// turns voice commands into ordered fm chip register writes, keeping the
// rhythm mode flag, the rhythm register shadow and the key/block shadows
// ---------------------------------------------------------------------------
module fm_voice_command_to_register_writes (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  fmv_pkg::t_in   i_in,
    output logic           o_valid,
    input  logic           i_stall,
    output fmv_pkg::t_out  o_out
);
    import fmv_pkg::*;

    logic             r_in_valid;
    t_in              r_in;
    logic             r_perc;
    logic [7:0]       r_rhythm;
    logic [7:0]       r_kb [NUM_KB];
    logic             emit_free;
    logic             load;
    logic [KB_W-1:0]  kb_rd_idx;
    logic [7:0]       kb_rd;
    t_dec             dec;
    t_upd             upd;

    // input register handshake
    assign load    = r_in_valid && emit_free;
    assign o_stall = r_in_valid && !load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in <= i_in;
        end
    end

    // key/block shadow read, out-of-range voices fall back to entry zero
    assign kb_rd_idx = (r_in.voice <= V_LAST_MEL) ? r_in.voice[KB_W-1:0] : '0;
    assign kb_rd     = r_kb[kb_rd_idx];

    fmv_decode u_decode (
        .i_item   (r_in),
        .i_perc   (r_perc),
        .i_rhythm (r_rhythm),
        .i_kb_rd  (kb_rd),
        .o_dec    (dec),
        .o_upd    (upd)
    );

    // voice state, updated as each command moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_perc   <= 1'b0;
            r_rhythm <= '0;
            for (int k = 0; k < NUM_KB; k++) begin
                r_kb[k] <= '0;
            end
        end else if (load) begin
            r_perc   <= upd.perc;
            r_rhythm <= upd.rhythm;
            if (upd.kb_we) begin
                r_kb[upd.kb_idx[KB_W-1:0]] <= upd.kb_val;
            end
        end
    end

    fmv_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_dec   (dec),
        .o_free  (emit_free),
        .o_valid (o_valid),
        .o_out   (o_out),
        .i_stall (i_stall)
    );

endmodule

@@ dv/tb_fm_voice_command_to_register_writes.sv @@
// ---------------------------------------------------------------------------
// tb_fm_voice_command_to_register_writes
// self-checking bench for the fm voice command sequencer: a directed table
// and random voice commands are sent with random gaps while the write side
// stalls at random; every register write is checked in order against the row's
// fixed expected write or an in-bench model of the rhythm flag, rhythm shadow and key/block shadows
// ---------------------------------------------------------------------------
module tb_fm_voice_command_to_register_writes;

    timeunit 1ns;
    timeprecision 1ps;

    import fmv_pkg::*;

    localparam int DIR_ROWS    = 25;
    localparam int RAND_ITEMS  = 435;
    localparam int DRAIN_WAIT  = 30;

    // opcodes the block does not implement
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    // single write of a rejected command
    localparam t_out REJECTED = '{8'h00, 8'h00, 1'b0, 1'b1};

    // operator slot to register offset, modulator and carrier slots per voice
    localparam logic [7:0] SLOT_REG [18] = '{
        8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h08, 8'h09, 8'h0A,
        8'h0B, 8'h0C, 8'h0D, 8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15
    };
    localparam int MOD_OF_VOICE [11] = '{0, 1, 2, 6, 7, 8, 12, 13, 14, 17, 13};
    localparam int CAR_OF_VOICE [9]  = '{3, 4, 5, 9, 10, 11, 15, 16, 17};
    localparam logic [7:0] OPER_REG [5] = '{8'h20, 8'h40, 8'h60, 8'h80, 8'hE0};

    typedef struct {
        t_in  cmd;
        bit   typed;
        t_out want;
    } t_stim_row;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_valid;
    logic  o_stall;
    t_in   i_in;
    logic  o_valid;
    logic  i_stall;
    t_out  o_out;

    // model state
    logic       perc_mode;
    logic [7:0] rhythm_bits;
    logic [7:0] keyblk [9];

    t_out cmd_writes[$];
    t_out pending_writes[$];
    int   mismatches;
    bit   tx_burst;
    bit   rx_burst;

    fm_voice_command_to_register_writes i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_in    (i_in),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_out   (o_out)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic t_in mk_cmd(input logic [2:0] op, input logic [3:0] voice,
                                   input logic [12:0] freq, input logic [7:0] vol,
                                   input logic pon, input logic [39:0] mb,
                                   input logic [39:0] cb, input logic [2:0] fb,
                                   input logic fm);
        t_in c;
        c.opcode          = op;
        c.voice           = voice;
        c.freq            = freq;
        c.volume          = vol;
        c.percussion_on   = pon;
        c.modulator_bytes = mb;
        c.carrier_bytes   = cb;
        c.feedback        = fb;
        c.fm_connection   = fm;
        return c;
    endfunction

    function automatic void add_write(input logic [7:0] addr, input logic [7:0] data);
        cmd_writes.push_back('{addr, data, 1'b1, 1'b0});
    endfunction

    // modulator register offset; the voice 7 slot moves with rhythm mode
    function automatic logic [7:0] mod_reg(input logic [3:0] voice);
        if (voice == V_SNARE) begin
            return perc_mode ? SLOT_REG[16] : SLOT_REG[13];
        end
        return SLOT_REG[MOD_OF_VOICE[voice]];
    endfunction

    // register writes of one command, with the shadow updates it causes
    task automatic expand_command(input t_in cmd);
        logic [7:0] mo;
        logic [7:0] co;
        logic [7:0] kb;
        logic [7:0] drum_bit;
        logic [7:0] vreg;
        logic       drum;
        cmd_writes.delete();
        drum = perc_mode && (cmd.voice > 4'd5);
        vreg = {4'h0, cmd.voice};
        if (cmd.opcode == OP_PERC) begin
            if (cmd.percussion_on) begin
                perc_mode   = 1'b1;
                rhythm_bits = RHYTHM_ON;
                add_write(REG_RHYTHM, RHYTHM_ON);
                add_write(REG_FNUM_LO + {4'h0, NOISE_CH_A}, NOISE_FREQ_A[7:0]);
                add_write(REG_KEYBLK + {4'h0, NOISE_CH_A}, {3'b000, NOISE_FREQ_A[12:8]});
                add_write(REG_FNUM_LO + {4'h0, NOISE_CH_B}, NOISE_FREQ_B[7:0]);
                add_write(REG_KEYBLK + {4'h0, NOISE_CH_B}, {3'b000, NOISE_FREQ_B[12:8]});
            end else begin
                perc_mode   = 1'b0;
                rhythm_bits = 8'h00;
                add_write(REG_RHYTHM, 8'h00);
            end
        end else if (cmd.opcode > OP_PERC ||
                     cmd.voice > (perc_mode ? V_LAST_DRUM : V_LAST_MEL)) begin
            cmd_writes.push_back(REJECTED);
        end else begin
            drum_bit = DRUM_TOP >> (cmd.voice - V_FIRST_DR);
            case (cmd.opcode)
                OP_KEY_ON: begin
                    if (drum) begin
                        rhythm_bits = rhythm_bits | drum_bit;
                        // only bass and tom carry a pitch
                        if (cmd.voice == V_BASS || cmd.voice == V_TOM) begin
                            add_write(REG_FNUM_LO + vreg, cmd.freq[7:0]);
                            add_write(REG_KEYBLK + vreg, {3'b000, cmd.freq[12:8]});
                        end
                        add_write(REG_RHYTHM, rhythm_bits);
                    end else begin
                        kb = {3'b000, cmd.freq[12:8]} | KEY_ON_BIT;
                        add_write(REG_FNUM_LO + vreg, cmd.freq[7:0]);
                        add_write(REG_KEYBLK + vreg, kb);
                        keyblk[cmd.voice] = kb;
                    end
                end
                OP_KEY_OFF: begin
                    if (drum) begin
                        rhythm_bits = rhythm_bits & ~drum_bit;
                        add_write(REG_RHYTHM, rhythm_bits);
                    end else begin
                        add_write(REG_KEYBLK + vreg, keyblk[cmd.voice] & KEY_OFF_MSK);
                    end
                end
                OP_VOLUME: begin
                    add_write(REG_LEVEL + mod_reg(cmd.voice), cmd.volume);
                end
                default: begin
                    mo = mod_reg(cmd.voice);
                    for (int k = 0; k < 5; k++) begin
                        add_write(OPER_REG[k] + mo, cmd.modulator_bytes[8*k +: 8]);
                    end
                    // drums 7..10 have a single operator
                    if (!perc_mode || cmd.voice < V_SNARE) begin
                        co = SLOT_REG[CAR_OF_VOICE[cmd.voice]];
                        for (int k = 0; k < 5; k++) begin
                            add_write(OPER_REG[k] + co, cmd.carrier_bytes[8*k +: 8]);
                        end
                        add_write(REG_FBCONN + vreg,
                                  {4'h0, cmd.feedback, ~cmd.fm_connection});
                    end
                end
            endcase
        end
        cmd_writes[cmd_writes.size()-1].last = 1'b1;
    endtask

    // one request: optional gap, hold until taken, then record its writes
    task automatic send_command(input t_in cmd, input bit typed, input t_out want);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in    <= cmd;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        expand_command(cmd);
        if (typed) begin
            pending_writes.push_back(want);
        end else begin
            foreach (cmd_writes[k]) pending_writes.push_back(cmd_writes[k]);
        end
    endtask

    task automatic random_command(output t_in cmd);
        int sel;
        sel = $urandom_range(0, 99);
        cmd = mk_cmd(OP_KEY_ON, 4'd0, 13'($urandom), 8'($urandom), 1'($urandom),
                     {8'($urandom), 32'($urandom)}, {8'($urandom), 32'($urandom)},
                     3'($urandom), 1'($urandom));
        if (sel < 6) begin
            cmd.opcode = OP_PERC;
        end else if (sel < 9) begin
            cmd.opcode = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        end else begin
            cmd.opcode = 3'($urandom_range(OP_KEY_ON, OP_INSTR));
        end
        if ($urandom_range(0, 9) == 0) begin
            cmd.voice = 4'($urandom_range(0, 15));
        end else begin
            cmd.voice = 4'($urandom_range(0, V_LAST_DRUM));
        end
    endtask

    function automatic void field_check(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // write side: random stall, then compare each taken write in order
    initial begin : write_side
        int   hold;
        int   taken;
        t_out want;
        i_stall  <= 1'b0;
        rx_burst = 1'b0;
        taken    = 0;
        @(posedge i_clk iff i_rst_n === 1'b1);
        forever begin
            if (taken % 40 == 0) begin
                rx_burst = ($urandom_range(0, 3) == 0);
            end
            hold = rx_burst ? 0 : $urandom_range(0, 10);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!(o_valid === 1'b1 && i_stall === 1'b0));
            taken++;
            if (pending_writes.size() == 0) begin
                $display("%0t: unexpected write, expected none, actual %h %h valid %b last %b",
                         $time, o_out.reg_address, o_out.reg_data, o_out.write_valid,
                         o_out.last);
                mismatches++;
            end else begin
                want = pending_writes.pop_front();
                field_check("reg_address", want.reg_address, o_out.reg_address);
                field_check("reg_data", want.reg_data, o_out.reg_data);
                field_check("write_valid", {7'd0, want.write_valid}, {7'd0, o_out.write_valid});
                field_check("last", {7'd0, want.last}, {7'd0, o_out.last});
            end
        end
    end

    // command side: reset, directed table, random commands, drain
    initial begin : command_side
        t_stim_row directed [DIR_ROWS];
        t_in       cmd;
        mismatches  = 0;
        tx_burst    = 1'b0;
        perc_mode   = 1'b0;
        rhythm_bits = 8'h00;
        foreach (keyblk[k]) keyblk[k] = 8'h00;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_in    <= '0;

        // melodic rows, key off from reset shadows, rejects, then rhythm mode
        directed[0]  = '{mk_cmd(OP_KEY_OFF, 4'd0, 13'h0, 8'h0, 1'b0, '0, '0, 3'd0, 1'b0),
                         1'b1, '{REG_KEYBLK, 8'h00, 1'b1, 1'b1}};
        directed[1]  = '{mk_cmd(OP_KEY_OFF, 4'd8, 13'h0, 8'h0, 1'b0, '0, '0, 3'd0, 1'b0),
                         1'b1, '{8'hB8, 8'h00, 1'b1, 1'b1}};
        directed[2]  = '{mk_cmd(OP_KEY_ON, 4'd0, 13'h0, 8'h0, 1'b0, '0, '0, 3'd0, 1'b0),
                         1'b0, '0};
        directed[3]  = '{mk_cmd(OP_KEY_ON, 4'd8, 13'h1FFF, 8'h0, 1'b0, '0, '0, 3'd0, 1'b0),
                         1'b0, '0};
        directed[4]  = '{mk_cmd(OP_KEY_OFF, 4'd8, 13'h0, 8'h0, 1'b0, '0, '0, 3'd0, 1'b0),
                         1'b0, '0};
        directed[5]  = '{mk_cmd(OP_VOLUME, 4'd0, 13'h0, 8'hFF, 1'b0, '0, '0, 3'd0, 1'b0),
                         1'b0, '0};
        directed[6]  = '{mk_cmd(OP_VOLUME, 4'd8, 13'h0, 8'h00, 1'b0, '0, '0, 3'd0, 1'b0),
                         1'b0, '0};
        directed[7]  = '{mk_cmd(OP_INSTR, 4'd0, 13'h0, 8'h0, 1'b0, '1, '1, 3'd7, 1'b0),
                         1'b0, '0};
        directed[8]  = '{mk_cmd(OP_INSTR, 4'd7, 13'h0, 8'h0, 1'b0, '0, '0, 3'd0, 1'b1),
                         1'b0, '0};
        directed[9]  = '{mk_cmd(OP_INSTR, 4'd8, 13'h0, 8'h0, 1'b0, 40'h05_04_03_02_01,
                                40'h5A_A5_C3_3C_96, 3'd3, 1'b1), 1'b0, '0};
        directed[10] = '{mk_cmd(OP_KEY_ON, 4'd9, 13'h123, 8'h0, 1'b0, '0, '0, 3'd0, 1'b0),
                         1'b1, REJECTED};
        directed[11] = '{mk_cmd(OP_SPARE_LO, 4'd0, 13'h0, 8'h0, 1'b1, '0, '0, 3'd0, 1'b0),
                         1'b1, REJECTED};
        directed[12] = '{mk_cmd(OP_SPARE_HI, 4'd15, 13'h1FFF, 8'hFF, 1'b1, '1, '1, 3'd7, 1'b1),
                         1'b1, REJECTED};
        directed[13] = '{mk_cmd(OP_PERC, 4'd0, 13'h0, 8'h0, 1'b0, '0, '0, 3'd0, 1'b0),
                         1'b1, '{REG_RHYTHM, 8'h00, 1'b1, 1'b1}};
        directed[14] = '{mk_cmd(OP_PERC, 4'd0, 13'h0, 8'h0, 1'b1, '0, '0, 3'd0, 1'b0),
                         1'b0, '0};
        directed[15] = '{mk_cmd(OP_KEY_ON, 4'd6, 13'h1FFF, 8'h0, 1'b0, '0, '0, 3'd0, 1'b0),
                         1'b0, '0};
        directed[16] = '{mk_cmd(OP_KEY_ON, 4'd7, 13'h0AA, 8'h0, 1'b0, '0, '0, 3'd0, 1'b0),
                         1'b0, '0};
        directed[17] = '{mk_cmd(OP_KEY_ON, 4'd10, 13'h155, 8'h0, 1'b0, '0, '0, 3'd0, 1'b0),
                         1'b0, '0};
        directed[18] = '{mk_cmd(OP_KEY_OFF, 4'd6, 13'h0, 8'h0, 1'b0, '0, '0, 3'd0, 1'b0),
                         1'b0, '0};
        directed[19] = '{mk_cmd(OP_VOLUME, 4'd7, 13'h0, 8'h3C, 1'b0, '0, '0, 3'd0, 1'b0),
                         1'b0, '0};
        directed[20] = '{mk_cmd(OP_INSTR, 4'd7, 13'h0, 8'h0, 1'b0, '1, '1, 3'd7, 1'b0),
                         1'b0, '0};
        directed[21] = '{mk_cmd(OP_INSTR, 4'd6, 13'h0, 8'h0, 1'b0, 40'h11_22_33_44_55,
                                40'h66_77_88_99_AA, 3'd5, 1'b0), 1'b0, '0};
        directed[22] = '{mk_cmd(OP_KEY_ON, 4'd15, 13'h0, 8'h0, 1'b0, '0, '0, 3'd0, 1'b0),
                         1'b1, REJECTED};
        directed[23] = '{mk_cmd(OP_KEY_ON, 4'd3, 13'h0A5A, 8'h0, 1'b0, '0, '0, 3'd0, 1'b0),
                         1'b0, '0};
        directed[24] = '{mk_cmd(OP_PERC, 4'd0, 13'h0, 8'h0, 1'b0, '0, '0, 3'd0, 1'b0),
                         1'b1, '{REG_RHYTHM, 8'h00, 1'b1, 1'b1}};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[r]) begin
            send_command(directed[r].cmd, directed[r].typed, directed[r].want);
        end

        for (int n = 0; n < RAND_ITEMS; n++) begin
            // every 40 commands, pick at random between gappy and back-to-back stretches
            if (n % 40 == 0) begin
                tx_burst = ($urandom_range(0, 3) == 0);
            end
            random_command(cmd);
            send_command(cmd, 1'b0, '0);
        end
        i_valid <= 1'b0;

        while (pending_writes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
